// File: sv/assert_macros.svh
// Assertion macros used by the RTL module of the interpolator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CHK_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define CHK_PROP(lbl, prop, msg)
`define CHK_NEVER(lbl, cond, msg)
`endif
`endif

// File: sv/sti_pkg.sv
// Package with the word types and constants of the speed-to-pulse interpolator.
`default_nettype none
package sti_pkg;
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = 6;
  localparam int CFG_W = 15;
  localparam int FIX_SCALE = 1000;
  localparam int DIV_STEPS = 26;
  localparam int RECIP_SHIFT = 36;
  localparam logic [29:0] RECIP_MUL = 30'd549755814;
  localparam logic [CNT_W-1:0] COUNT_RESET = 6'd25;
  localparam logic [CFG_W-1:0] ZERO_RESET = 15'd1500;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_CONVERT = 1'b1;

  localparam logic [1:0] TSEL_POS_SPEED = 2'd0;
  localparam logic [1:0] TSEL_NEG_SPEED = 2'd1;
  localparam logic [1:0] TSEL_POS_PULSE = 2'd2;
  localparam logic [1:0] TSEL_NEG_PULSE = 2'd3;

  localparam logic REG_ZERO_PULSE = 1'b0;
  localparam logic REG_TABLE_COUNT = 1'b1;

  typedef struct packed {
    logic kind;
    logic [1:0] table_select;
    logic [4:0] entry_index;
    logic signed [15:0] entry_value;
    logic signed [15:0] commanded_speed;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] pulse_width;
    logic clamped;
    logic bad_segment;
  } rsp_t;
endpackage
`default_nettype wire

// File: sv/speed_to_pulse_interpolator.sv
// Top level of the speed-to-pulse interpolator: tables, lookup and fixed-point pipeline.
//
// A command word on cmd either loads one entry of one of the four breakpoint
// tables or converts a commanded speed into a pulse width. A load gives no
// response word; a convert gives exactly one word on rsp. Words are taken
// when valid is high and stall is low on the same rising edge.
// The block is one pipeline that takes a new word in every cycle while rsp
// is not stalled. A convert word passes the 26 stages of the restoring
// divider for the segment slope plus the lookup, multiply and scaling
// stages around it before it appears on rsp. Loads are written into the
// tables as they are taken, so every later convert sees them. When rsp is
// stalled with a word waiting, the whole pipeline holds and cmd is stalled
// in the same cycle; nothing is lost or repeated. Synchronous reset empties
// the pipeline and sets zero_pulse to 1500 and table_count to 25. The tables
// are not cleared; every entry that a convert reads must be loaded first.
// Configuration must be written on cfg only while idle; nothing enforces it.
`default_nettype none
`include "assert_macros.svh"
module speed_to_pulse_interpolator
  import sti_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic cmd_valid,
  output logic cmd_stall,
  input  wire cmd_t cmd,
  output logic rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t rsp
);

  typedef struct packed {
    logic direct;
    logic clamped;
    logic [15:0] pw;
    logic [15:0] ss;
    logic [15:0] se;
    logic [15:0] ps;
    logic [15:0] pe;
    logic signed [16:0] s;
  } look_t;

  typedef struct packed {
    logic direct;
    logic clamped;
    logic bad;
    logic [15:0] pw;
    logic signed [17:0] off;
    logic signed [31:0] ps1000;
  } ctl_t;

  logic [CFG_W-1:0] zero_pulse;
  logic [CNT_W-1:0] table_count;
  logic [15:0] pos_spd [TABLE_DEPTH];
  logic [15:0] neg_spd [TABLE_DEPTH];
  logic [15:0] pos_pls [TABLE_DEPTH];
  logic [15:0] neg_pls [TABLE_DEPTH];

  logic advance;
  logic s1_valid;
  cmd_t s1_cmd;
  look_t look;
  logic s2_valid;
  look_t s2;
  logic s3_valid;
  ctl_t s3_ctl;
  logic signed [26:0] s3_dpw;
  logic signed [16:0] s3_dsp;

  logic dv_valid [DIV_STEPS+1];
  ctl_t dv_ctl [DIV_STEPS+1];
  logic [15:0] dv_rem [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] dv_num [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] dv_quo [DIV_STEPS+1];
  logic [15:0] dv_den [DIV_STEPS+1];
  logic dv_qneg [DIV_STEPS+1];

  logic m_valid;
  ctl_t m_ctl;
  logic [31:0] m_prod;
  logic a_valid;
  ctl_t a_ctl;
  logic [31:0] a_acc;
  logic b_valid;
  ctl_t b_ctl;
  logic b_neg;
  logic [28:0] b_x;
  logic c_valid;
  ctl_t c_ctl;
  logic c_neg;
  logic [22:0] c_q;

  logic signed [26:0] slope;
  logic [58:0] recip_prod;
  logic [15:0] fin_pw;
  logic signed [16:0] dsp_w;
  logic signed [16:0] dpd_w;
  logic signed [26:0] dpw_w;
  logic [31:0] acc_mag;

  assign advance = !rsp_valid || !rsp_stall;
  assign cmd_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_pulse <= ZERO_RESET;
      table_count <= COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ZERO_PULSE: zero_pulse <= cfg_data;
        REG_TABLE_COUNT: table_count <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall && cmd.kind == KIND_LOAD) begin
      case (cmd.table_select)
        TSEL_POS_SPEED: pos_spd[cmd.entry_index] <= cmd.entry_value;
        TSEL_NEG_SPEED: neg_spd[cmd.entry_index] <= cmd.entry_value;
        TSEL_POS_PULSE: pos_pls[cmd.entry_index] <= cmd.entry_value;
        default: neg_pls[cmd.entry_index] <= cmd.entry_value;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_cmd <= cmd;
    end
  end

  // Segment search: all compares run side by side against the table registers.
  always_comb begin
    logic [IDX_W-1:0] last;
    logic signed [16:0] s;
    logic [15:0] p_last_s, p_last_p, n_last_s, n_last_p;
    logic p_found, n_found;
    look_t p_seg, n_seg;
    if (table_count < CNT_W'(2)) begin
      last = IDX_W'(1);
    end else if (table_count > CNT_W'(TABLE_DEPTH)) begin
      last = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      last = IDX_W'(table_count - CNT_W'(1));
    end
    s = -{s1_cmd.commanded_speed[15], s1_cmd.commanded_speed};
    p_last_s = '0;
    p_last_p = '0;
    n_last_s = '0;
    n_last_p = '0;
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      if (IDX_W'(j) == last) begin
        p_last_s = pos_spd[j];
        p_last_p = pos_pls[j];
        n_last_s = neg_spd[j];
        n_last_p = neg_pls[j];
      end
    end
    p_found = 1'b0;
    n_found = 1'b0;
    p_seg = '0;
    n_seg = '0;
    for (int j = 1; j < TABLE_DEPTH; j++) begin
      if (!p_found && IDX_W'(j) <= last &&
          s <= $signed({pos_spd[j][15], pos_spd[j]})) begin
        p_found = 1'b1;
        p_seg.ss = pos_spd[j-1];
        p_seg.se = pos_spd[j];
        p_seg.ps = pos_pls[j-1];
        p_seg.pe = pos_pls[j];
      end
      if (!n_found && IDX_W'(j) <= last &&
          s >= $signed({neg_spd[j][15], neg_spd[j]})) begin
        n_found = 1'b1;
        n_seg.ss = neg_spd[j-1];
        n_seg.se = neg_spd[j];
        n_seg.ps = neg_pls[j-1];
        n_seg.pe = neg_pls[j];
      end
    end
    look = '0;
    look.s = s;
    look.direct = 1'b1;
    look.pw = {1'b0, zero_pulse};
    if (s == 17'sd0) begin
      look.pw = {1'b0, zero_pulse};
    end else if (s >= $signed({p_last_s[15], p_last_s})) begin
      look.pw = p_last_p;
      look.clamped = 1'b1;
    end else if (s <= $signed({n_last_s[15], n_last_s})) begin
      look.pw = n_last_p;
      look.clamped = 1'b1;
    end else if (s <= $signed({pos_spd[0][15], pos_spd[0]}) && s > 17'sd0) begin
      look.pw = pos_pls[0];
    end else if (s <= $signed({pos_spd[0][15], pos_spd[0]}) &&
                 s >= $signed({neg_spd[0][15], neg_spd[0]})) begin
      look.pw = neg_pls[0];
    end else if (s <= $signed({pos_spd[0][15], pos_spd[0]}) && n_found) begin
      look.direct = 1'b0;
      look.ss = n_seg.ss;
      look.se = n_seg.se;
      look.ps = n_seg.ps;
      look.pe = n_seg.pe;
    end else if (p_found) begin
      look.direct = 1'b0;
      look.ss = p_seg.ss;
      look.se = p_seg.se;
      look.ps = p_seg.ps;
      look.pe = p_seg.pe;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid && s1_cmd.kind == KIND_CONVERT;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2 <= look;
    end
  end

  assign dsp_w = $signed({s2.se[15], s2.se}) - $signed({s2.ss[15], s2.ss});
  assign dpd_w = $signed({s2.pe[15], s2.pe}) - $signed({s2.ps[15], s2.ps});
  assign dpw_w = 27'(dpd_w * $signed(11'(FIX_SCALE)));

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_ctl.direct <= s2.direct || dsp_w == 17'sd0;
      s3_ctl.clamped <= s2.clamped;
      s3_ctl.bad <= !s2.direct && dsp_w == 17'sd0;
      s3_ctl.pw <= s2.direct ? s2.pw : s2.ps;
      s3_ctl.off <= {s2.s[16], s2.s} - $signed({{2{s2.ss[15]}}, s2.ss});
      s3_ctl.ps1000 <= 32'($signed(s2.ps) * $signed(11'(FIX_SCALE)));
      s3_dpw <= dpw_w;
      s3_dsp <= dsp_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (advance) begin
      dv_valid[0] <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dv_ctl[0] <= s3_ctl;
      dv_rem[0] <= '0;
      dv_num[0] <= DIV_STEPS'(s3_dpw[26] ? -s3_dpw : s3_dpw);
      dv_den[0] <= 16'(s3_dsp[16] ? -s3_dsp : s3_dsp);
      dv_quo[0] <= '0;
      dv_qneg[0] <= s3_dpw[26] ^ s3_dsp[16];
    end
  end

  // Restoring divider for the slope, one quotient bit per stage.
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic [16:0] trial;
    logic take;
    assign trial = {dv_rem[i], dv_num[i][DIV_STEPS-1]};
    assign take = trial >= {1'b0, dv_den[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[i+1] <= 1'b0;
      end else if (advance) begin
        dv_valid[i+1] <= dv_valid[i];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        dv_ctl[i+1] <= dv_ctl[i];
        dv_rem[i+1] <= take ? 16'(trial - {1'b0, dv_den[i]}) : trial[15:0];
        dv_num[i+1] <= {dv_num[i][DIV_STEPS-2:0], 1'b0};
        dv_quo[i+1] <= {dv_quo[i][DIV_STEPS-2:0], take};
        dv_den[i+1] <= dv_den[i];
        dv_qneg[i+1] <= dv_qneg[i];
      end
    end
  end

  assign slope = dv_qneg[DIV_STEPS] ? -$signed({1'b0, dv_quo[DIV_STEPS]})
                                    : $signed({1'b0, dv_quo[DIV_STEPS]});

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (advance) begin
      m_valid <= dv_valid[DIV_STEPS];
      a_valid <= m_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  assign acc_mag = a_acc[31] ? 32'(-a_acc) : a_acc;
  assign recip_prod = 59'(b_x) * 59'(RECIP_MUL);

  always_ff @(posedge clk) begin
    if (advance) begin
      m_ctl <= dv_ctl[DIV_STEPS];
      m_prod <= 32'(slope * dv_ctl[DIV_STEPS].off);
      a_ctl <= m_ctl;
      a_acc <= 32'(m_ctl.ps1000) + m_prod;
      b_ctl <= a_ctl;
      b_neg <= a_acc[31];
      b_x <= acc_mag[31:3];
      c_ctl <= b_ctl;
      c_neg <= b_neg;
      c_q <= recip_prod[58:RECIP_SHIFT];
    end
  end

  assign fin_pw = c_ctl.direct ? c_ctl.pw
                : (c_neg ? 16'(-c_q[15:0]) : c_q[15:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.pulse_width <= fin_pw;
      rsp.clamped <= c_ctl.clamped;
      rsp.bad_segment <= c_ctl.bad;
    end
  end

  `CHK_PROP(a_load_no_rsp, s1_valid && s1_cmd.kind == KIND_LOAD && advance |=> !s2_valid, "load word entered the result pipeline")
  `CHK_NEVER(a_bad_direct, s3_valid && s3_ctl.bad && !s3_ctl.direct, "bad segment not taken as direct")
  `CHK_NEVER(a_flags_excl, rsp_valid && rsp.clamped && rsp.bad_segment, "clamped and bad segment both set")
  `CHK_NEVER(a_div_rem, dv_valid[DIV_STEPS] && !dv_ctl[DIV_STEPS].direct && dv_rem[DIV_STEPS] >= dv_den[DIV_STEPS], "divider remainder not below divisor")
  `CHK_PROP(a_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(c_ctl) && $stable(m_prod), "pipeline moved during stall")

endmodule
`default_nettype wire

// File: sim/tb_speed_to_pulse_interpolator.sv
// Testbench for the speed-to-pulse interpolator: tables, lookups and response checking.
`default_nettype none
module tb_speed_to_pulse_interpolator;
  import sti_pkg::*;

  class pulse_scoreboard;
    logic [15:0] pos_spd [TABLE_DEPTH];
    logic [15:0] neg_spd [TABLE_DEPTH];
    logic [15:0] pos_pw [TABLE_DEPTH];
    logic [15:0] neg_pw [TABLE_DEPTH];
    logic [14:0] zero_pw;
    logic [5:0] count;
    rsp_t pending[$];
    int errors;

    function new();
      zero_pw = ZERO_RESET;
      count = COUNT_RESET;
      errors = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        pos_spd[i] = '0;
        neg_spd[i] = '0;
        pos_pw[i] = '0;
        neg_pw[i] = '0;
      end
    endfunction

    function void set_reg(logic idx, logic [14:0] val);
      if (idx == REG_ZERO_PULSE) zero_pw = val;
      else count = val[5:0];
    endfunction

    function logic [15:0] segment(bit neg, int k, int s, ref bit bad);
      int ss, se, ps, pe, dsp, slope;
      logic [31:0] acc;
      ss = neg ? $signed(neg_spd[k-1]) : $signed(pos_spd[k-1]);
      se = neg ? $signed(neg_spd[k]) : $signed(pos_spd[k]);
      ps = neg ? $signed(neg_pw[k-1]) : $signed(pos_pw[k-1]);
      pe = neg ? $signed(neg_pw[k]) : $signed(pos_pw[k]);
      dsp = se - ss;
      if (dsp == 0) begin
        bad = 1;
        return ps[15:0];
      end
      slope = ((pe - ps) * 1000) / dsp;
      acc = ps * 1000 + slope * (s - ss);
      return 16'($signed(acc) / 1000);
    endfunction

    function void note_command(cmd_t c);
      int n, s;
      rsp_t r;
      bit bad;
      logic [15:0] pw;
      bit done;
      if (c.kind == KIND_LOAD) begin
        case (c.table_select)
          TSEL_POS_SPEED: pos_spd[c.entry_index] = c.entry_value;
          TSEL_NEG_SPEED: neg_spd[c.entry_index] = c.entry_value;
          TSEL_POS_PULSE: pos_pw[c.entry_index] = c.entry_value;
          default: neg_pw[c.entry_index] = c.entry_value;
        endcase
        return;
      end
      n = count;
      if (n < 2) n = 2;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      s = -int'(c.commanded_speed);
      r = '0;
      bad = 0;
      done = 0;
      pw = {1'b0, zero_pw};
      if (s == 0) done = 1;
      else if (s >= $signed(pos_spd[n-1])) begin
        pw = pos_pw[n-1]; r.clamped = 1; done = 1;
      end else if (s <= $signed(neg_spd[n-1])) begin
        pw = neg_pw[n-1]; r.clamped = 1; done = 1;
      end else if (s <= $signed(pos_spd[0])) begin
        if (s > 0) begin
          pw = pos_pw[0]; done = 1;
        end else if (s >= $signed(neg_spd[0])) begin
          pw = neg_pw[0]; done = 1;
        end else
          for (int k = 1; k < n && !done; k++)
            if (s >= $signed(neg_spd[k])) begin
              pw = segment(1, k, s, bad); done = 1;
            end
      end
      for (int k = 1; k < n && !done; k++)
        if (s <= $signed(pos_spd[k])) begin
          pw = segment(0, k, s, bad); done = 1;
        end
      r.pulse_width = pw;
      r.bad_segment = bad;
      pending.push_back(r);
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      if (pending.size() == 0) begin
        $error("unexpected response word %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.pulse_width !== e.pulse_width) begin
        $error("pulse_width expected %0d got %0d", e.pulse_width, got.pulse_width);
        errors++;
      end
      if (got.clamped !== e.clamped) begin
        $error("clamped expected %0b got %0b", e.clamped, got.clamped);
        errors++;
      end
      if (got.bad_segment !== e.bad_segment) begin
        $error("bad_segment expected %0b got %0b", e.bad_segment, got.bad_segment);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_index = REG_ZERO_PULSE;
  logic [CFG_W-1:0] cfg_data = '0;
  logic cmd_valid = 0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 0;
  rsp_t rsp;

  pulse_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int cycle = 0;
  int speed_span = 1000;

  speed_to_pulse_interpolator dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 600000) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp_stall <= 1;
    end else
      rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  // The word stays valid after it was taken until the next send or a drain.
  task automatic send(cmd_t c);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      cmd_valid <= 0;
      @(negedge clk);
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
    cmd <= c;
    cmd_valid <= 1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sb.note_command(c);
    @(negedge clk);
  endtask

  task automatic load(logic [1:0] sel, int idx, int val);
    cmd_t c;
    c = '0;
    c.kind = KIND_LOAD;
    c.table_select = sel;
    c.entry_index = 5'(idx);
    c.entry_value = 16'(val);
    c.commanded_speed = 16'($urandom);
    send(c);
  endtask

  task automatic convert(int spd);
    cmd_t c;
    c = '0;
    c.table_select = 2'($urandom);
    c.entry_index = 5'($urandom);
    c.entry_value = 16'($urandom);
    c.kind = KIND_CONVERT;
    c.commanded_speed = 16'(spd);
    send(c);
  endtask

  task automatic drain();
    cmd_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    @(negedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, CFG_W'(val));
    @(negedge clk);
  endtask

  // Fills all four tables with monotonic breakpoints; some segments have zero width.
  task automatic fill_tables(int step);
    int ps, ns;
    ps = $urandom_range(step);
    ns = -$urandom_range(step);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      load(TSEL_POS_SPEED, i, ps);
      load(TSEL_NEG_SPEED, i, ns);
      load(TSEL_POS_PULSE, i, $signed(16'($urandom)));
      load(TSEL_NEG_PULSE, i, $signed(16'($urandom)));
      if ($urandom_range(9) != 0) ps = ps + $urandom_range(1, step);
      if ($urandom_range(9) != 0) ns = ns - $urandom_range(1, step);
      if (ps > 32767) ps = 32767;
      if (ns < -32768) ns = -32768;
    end
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 8) load(2'($urandom), $urandom_range(31), $signed(16'($urandom)));
    else if (r < 15) convert($signed(16'($urandom)));
    else convert($urandom_range(2 * speed_span) - speed_span);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: full-range tables, edges of speed, zero and clamps.
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      load(TSEL_POS_SPEED, i, i * 1000 + 1);
      load(TSEL_NEG_SPEED, i, -i * 1000 - 1);
      load(TSEL_POS_PULSE, i, (i % 2) ? 32767 : -32768);
      load(TSEL_NEG_PULSE, i, 1000 + i * 37);
    end
    load(TSEL_POS_SPEED, 3, 2001);
    convert(0);
    convert(32767);
    convert(-32768);
    convert(-1);
    convert(1);
    convert(-2500);
    convert(2500);
    convert(-2001);
    convert(-24001);
    convert(24001);
    drain();
    write_reg(REG_ZERO_PULSE, 20000);
    write_reg(REG_TABLE_COUNT, 32);
    convert(0);
    convert(-31500);
    convert(-32767);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 75; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 75; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      case (phase)
        0: write_reg(REG_TABLE_COUNT, 2);
        1: write_reg(REG_TABLE_COUNT, 0);
        2: write_reg(REG_TABLE_COUNT, 63);
        3: write_reg(REG_TABLE_COUNT, 7);
        default: write_reg(REG_TABLE_COUNT, $urandom_range(2, 32));
      endcase
      write_reg(REG_ZERO_PULSE, phase == 4 ? 0 : $urandom_range(20000));
      speed_span = (phase % 2) ? 32768 : 4000;
      fill_tables(phase % 2 ? 1000 : 120);
      if (phase == 5) hold_cycles = 400;
      repeat (36) random_item();
      drain();
    end
    idle_pct = 0;
    stall_pct = 0;
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
